// File: rtl/core/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, constants and functions for the sample distorter.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int CARRIER_DEPTH_DEF = 1024;
    localparam int FOLD_ITER_DEF     = 64;
    localparam int SAMPLE_BITS_DEF   = 16;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_THRESH  = 3'd1,
        REG_AMOUNT  = 3'd2,
        REG_QLEVELS = 3'd3,
        REG_HOLD    = 3'd4,
        REG_PSTEP   = 3'd5,
        REG_WET     = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_CLIP_LOW  = 3'd0,
        MODE_CLIP_HIGH = 3'd1,
        MODE_FOLD      = 3'd2,
        MODE_CRUSH     = 3'd3,
        MODE_RING      = 3'd4,
        MODE_SQUARE    = 3'd5
    } effect_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_DIV1,
        ST_SIN1,
        ST_SIN2,
        ST_SIN3,
        ST_SIN4,
        ST_SIN5,
        ST_RINGMUL,
        ST_MIX,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  effect_mode;
        logic [14:0] threshold;
        logic [15:0] amount;
        logic [10:0] quant_levels;
        logic [10:0] hold_length;
        logic [15:0] phase_step;
        logic [10:0] wet_mix;
    } cfg_t;

    // clamp a signed value to [lo, hi]
    function automatic logic signed [47:0] sat48(input logic signed [47:0] v,
                                                 input logic signed [47:0] lo,
                                                 input logic signed [47:0] hi);
        logic signed [47:0] r;
        r = v;
        if (v > hi)
            r = hi;
        if (v < lo)
            r = lo;
        return r;
    endfunction

endpackage

// File: rtl/core/msd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_stream_if / msd_cfg_if
// Valid/ready channels for samples and for register writes.
// ----------------------------------------------------------------------------
interface msd_stream_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface msd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/msd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_divider
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module msd_divider
    import msd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [10:0] divisor,
    output logic        done,
    output logic [39:0] quotient,
    output logic        rem_nz
);
    logic [39:0] q_reg, q_next;
    logic [11:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [11:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[10:0], q_reg[39]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign rem_nz   = (r_reg != '0);
endmodule

// File: rtl/core/msd_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_multiplier
// Shared registered signed multiplier; the product is ready in the cycle after the operands.
// ----------------------------------------------------------------------------
module msd_multiplier
    import msd_pkg::*;
(
    input  logic               clk,
    input  logic signed [24:0] op_a,
    input  logic signed [24:0] op_b,
    output logic signed [49:0] product
);
    logic signed [49:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;
endmodule

// File: rtl/core/multimode_sample_distorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multimode_sample_distorter
// Clip, fold, crush, ring modulate or square one sample, then wet/dry mix.
// ----------------------------------------------------------------------------
//  channel   dir  payload          notes
//  in_ch     in   sample           one request per sample
//  out_ch    out  sample           one result per request
//  cfg_ch    in   index, data      register writes, always ready
//
//  Clip, square and unused modes go straight to the mix. Wavefolder: one
//  fold step at a time, at most FOLD_MAX_ITER steps. Bitcrusher: the
//  40-step divide by quant_levels. Ring modulator: two sines through the
//  shared multiplier. in_ch.ready is high only in idle; a held result
//  stalls it. Reset restores the register defaults and clears the state,
//  hold counter, held sample and carrier phase.
// ----------------------------------------------------------------------------
module multimode_sample_distorter
    import msd_pkg::*;
#(
    parameter int CARRIER_TABLE_DEPTH = CARRIER_DEPTH_DEF,
    parameter int FOLD_MAX_ITER       = FOLD_ITER_DEF,
    parameter int SAMPLE_BITS         = SAMPLE_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    msd_stream_if.sink   in_ch,
    msd_stream_if.source out_ch,
    msd_cfg_if.sink      cfg_ch
);
    localparam int SW   = SAMPLE_BITS;
    localparam int DW   = $clog2(CARRIER_TABLE_DEPTH);
    localparam int ITW  = $clog2(FOLD_MAX_ITER + 1);
    localparam logic signed [47:0] SCALE = 48'sd1 <<< (SW - 1);

    cfg_t cfg_reg, cfg_next;
    seq_state_t st_reg, st_next;
    logic signed [SW-1:0] held_reg, held_next;
    logic [9:0]  hcnt_reg, hcnt_next;
    logic [15:0] phase_reg, phase_next;
    logic signed [SW-1:0] x_reg, x_next;
    logic signed [47:0] s_reg, s_next;
    logic signed [47:0] t_reg, t_next;
    logic signed [47:0] acc_reg, acc_next;
    logic [ITW-1:0] it_reg, it_next;
    logic [1:0] quad_reg, quad_next;
    logic       pass_reg, pass_next;
    logic signed [SW-1:0] out_reg, out_next;
    logic       neg_reg, neg_next;

    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] product;
    logic        div_start;
    logic [39:0] div_dividend;
    logic        div_done;
    logic [39:0] div_q;
    logic        div_rem_nz;

    msd_multiplier u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .product(product));
    msd_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_dividend), .divisor(cfg_reg.quant_levels), .done(div_done),
        .quotient(div_q), .rem_nz(div_rem_nz));

    logic signed [47:0] T, A, xs, magx, wmix, mixv;
    logic [15:0] u_cur, u1, u2;
    logic [DW-1:0] cidx;
    logic [47:0] fx, x2;
    logic signed [47:0] divq_s;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (st_reg == ST_IDLE);
    assign out_ch.valid = (st_reg == ST_OUT);
    assign out_ch.sample = out_reg;

    always_comb
    begin
        T    = 48'(cfg_reg.threshold);
        A    = 48'(cfg_reg.amount);
        xs   = 48'(x_reg);
        magx = (xs < 0) ? -xs : xs;
        wmix = (cfg_reg.wet_mix > 11'd1024) ? 48'sd1024 : 48'(cfg_reg.wet_mix);
        cidx = DW'((32'(phase_reg) * CARRIER_TABLE_DEPTH) >> 16);
        u1   = 16'((32'(cidx) * 65536) / CARRIER_TABLE_DEPTH);
        u2   = 16'((40'(cidx) * 40'd327680) / (2 * CARRIER_TABLE_DEPTH));
        u_cur = pass_reg ? u2 : u1;
        fx   = 48'({(u_cur[14] ? (16'd16384 - {2'b0, u_cur[13:0]})
                               : {2'b0, u_cur[13:0]}), 2'b00});
        x2   = 48'(product[47:16]);
        divq_s = neg_reg ? -$signed(48'(div_q)) - (div_rem_nz ? 48'sd1 : 48'sd0)
                         : $signed(48'(div_q));
        mixv = acc_reg;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (in_ch.valid)
                begin
                    case (cfg_reg.effect_mode)
                        MODE_FOLD:  st_next = ST_FOLD;
                        MODE_CRUSH: st_next = ST_DIV1;
                        MODE_RING:  st_next = ST_SIN1;
                        default:    st_next = ST_MIX;
                    endcase
                end
            ST_FOLD:
                if (pass_reg && (it_reg == ITW'(FOLD_MAX_ITER) || (s_reg <= T && s_reg >= -T)))
                    st_next = ST_MIX;
            ST_DIV1:    if (div_done) st_next = ST_MIX;
            ST_SIN1:    st_next = ST_SIN2;
            ST_SIN2:    st_next = ST_SIN3;
            ST_SIN3:    st_next = ST_SIN4;
            ST_SIN4:    st_next = ST_SIN5;
            ST_SIN5:    if (it_reg != ITW'(0)) st_next = pass_reg ? ST_RINGMUL : ST_SIN1;
            ST_RINGMUL: if (it_reg == ITW'(2)) st_next = ST_MIX;
            ST_MIX:     if (it_reg == ITW'(1)) st_next = ST_OUT;
            ST_OUT:     if (out_ch.ready) st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        logic signed [47:0] sn, p, r;
        logic [3:0] sub;
        cfg_next   = cfg_reg;
        held_next  = held_reg;
        hcnt_next  = hcnt_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        it_next    = it_reg;
        quad_next  = quad_reg;
        pass_next  = pass_reg;
        out_next   = out_reg;
        neg_next   = neg_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_dividend = '0;
        p  = 48'(product);
        sn = s_reg;
        r  = '0;
        sub = 4'(it_reg);

        if (cfg_ch.valid)
        begin
            case (cfg_reg_t'(cfg_ch.index))
                REG_MODE:    cfg_next.effect_mode  = cfg_ch.data[2:0];
                REG_THRESH:  cfg_next.threshold    = cfg_ch.data[14:0];
                REG_AMOUNT:  cfg_next.amount       = cfg_ch.data;
                REG_QLEVELS: cfg_next.quant_levels = cfg_ch.data[10:0];
                REG_HOLD:    cfg_next.hold_length  = cfg_ch.data[10:0];
                REG_PSTEP:   cfg_next.phase_step   = cfg_ch.data;
                REG_WET:     cfg_next.wet_mix      = cfg_ch.data[10:0];
                default: ;
            endcase
        end

        case (st_reg)
            ST_IDLE:
            begin
                it_next   = '0;
                pass_next = 1'b0;
                if (in_ch.valid)
                begin
                    x_next = in_ch.sample;
                    case (cfg_reg.effect_mode)
                        MODE_CLIP_LOW:
                            s_next = (((in_ch.sample < 0) ? -48'(in_ch.sample)
                                      : 48'(in_ch.sample)) < T) ? A : 48'(in_ch.sample);
                        MODE_CLIP_HIGH:
                            s_next = (48'(in_ch.sample) > T) ? A :
                                     (48'(in_ch.sample) < -T) ? -A : 48'(in_ch.sample);
                        MODE_SQUARE:
                            s_next = (48'(in_ch.sample) + T > 0) ? SCALE :
                                     (48'(in_ch.sample) + T + A > 0) ? 48'sd0 : -SCALE;
                        MODE_CRUSH:
                        begin
                            r = (hcnt_reg == 10'd0) ? 48'(in_ch.sample) : 48'(held_reg);
                            if (hcnt_reg == 10'd0)
                                held_next = in_ch.sample;
                            // scale by the levels, quantise to steps of full scale, then divide by the levels
                            r = ((r * $signed(48'(cfg_reg.quant_levels))) >>> (SW - 1))
                                <<< (SW - 1);
                            neg_next = r < 0;
                            div_start = 1'b1;
                            div_dividend = 40'((r < 0) ? -r : r);
                            if (cfg_reg.hold_length > 11'd1024)
                                hcnt_next = ((11'(hcnt_reg) + 11'd1) >= 11'd1024) ? 10'd0 : hcnt_reg + 10'd1;
                            else
                                hcnt_next = ((11'(hcnt_reg) + 11'd1) >= cfg_reg.hold_length) ? 10'd0
                                            : hcnt_reg + 10'd1;
                        end
                        default: s_next = '0;
                    endcase
                end
            end
            ST_FOLD:
            begin
                if (!pass_reg)
                begin
                    mul_a = 25'(x_reg);
                    mul_b = 25'(48'sd32768 + A);
                    pass_next = it_reg == ITW'(1);
                    it_next = it_reg + ITW'(1);
                    if (it_reg == ITW'(1))
                    begin
                        s_next = p >>> 15;
                        it_next = '0;
                    end
                end
                else
                begin
                    if (it_reg == ITW'(FOLD_MAX_ITER) || (s_reg <= T && s_reg >= -T))
                    begin
                        s_next = sat48(s_reg, -T, T);
                        it_next = '0;
                    end
                    else
                    begin
                        sn = (s_reg > T) ? T - s_reg : T + s_reg;
                        s_next = sn;
                        it_next = it_reg + ITW'(1);
                    end
                end
            end
            ST_DIV1:
                if (div_done)
                    s_next = (1000 * magx < 5 * SCALE || cfg_reg.quant_levels == 11'd0)
                             ? 48'sd0 : divq_s;
            ST_SIN1:
            begin
                quad_next = u_cur[15:14];
                t_next = fx;
                mul_a = 25'(fx);
                mul_b = 25'(fx);
                it_next = '0;
            end
            ST_SIN2:
            begin
                acc_next = 48'(x2);
                mul_a = 25'(x2);
                mul_b = 25'sd307;
            end
            ST_SIN3:
            begin
                sn = 48'sd5223 - (p >>> 16);
                mul_a = 25'(acc_reg);
                mul_b = 25'(sn);
            end
            ST_SIN4:
            begin
                sn = 48'sd42334 - (p >>> 16);
                mul_a = 25'(acc_reg);
                mul_b = 25'(sn);
            end
            ST_SIN5:
            begin
                if (it_reg == ITW'(0))
                begin
                    sn = 48'sd102944 - (p >>> 16);
                    mul_a = 25'(t_reg);
                    mul_b = 25'(sn);
                    it_next = ITW'(1);
                end
                else
                begin
                    sn = ((p >>> 16) + 1) >>> 1;
                    if (sn > 48'sd32767)
                        sn = 48'sd32767;
                    if (quad_reg[1])
                        sn = -sn;
                    if (!pass_reg)
                    begin
                        s_next = sn * 48'sd21299;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        s_next = (s_reg + sn * 48'sd9830) >>> 15;
                        it_next = '0;
                    end
                end
            end
            ST_RINGMUL:
            begin
                mul_a = 25'(x_reg);
                mul_b = 25'(s_reg);
                it_next = it_reg + ITW'(1);
                if (it_reg == ITW'(2))
                begin
                    s_next = (1000 * magx < SCALE) ? 48'sd0 : (p >>> 15);
                    phase_next = phase_reg + cfg_reg.phase_step;
                    it_next = '0;
                end
            end
            ST_MIX:
            begin
                it_next = it_reg + ITW'(1);
                if (it_reg == ITW'(0))
                begin
                    if (cfg_reg.effect_mode > 3'd5)
                        s_next = '0;
                    acc_next = (wmix * ((cfg_reg.effect_mode > 3'd5) ? 48'sd0 : s_reg)
                                + (48'sd1024 - wmix) * xs) >>> 10;
                end
                else
                    out_next = SW'(sat48(mixv, -SCALE, SCALE - 1));
            end
            default: ;
        endcase
        if (sub == 4'hF)
            neg_next = neg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '{effect_mode: MODE_CLIP_LOW, threshold: 15'd983, amount: 16'd0,
                           quant_levels: 11'd1024, hold_length: 11'd1,
                           phase_step: 16'd20480, wet_mix: 11'd1024};
            st_reg    <= ST_IDLE;
            held_reg  <= '0;
            hcnt_reg  <= '0;
            phase_reg <= '0;
            it_reg    <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            st_reg    <= st_next;
            held_reg  <= held_next;
            hcnt_reg  <= hcnt_next;
            phase_reg <= phase_next;
            it_reg    <= it_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        quad_reg <= quad_next;
        out_reg  <= out_next;
        neg_reg  <= neg_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.sample)))
        else $error("result dropped");
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_RINGMUL) |=> $stable(phase_reg)) else $error("phase moved");
endmodule
